>>> sv/assert_macros.svh
// assertion macros used by the hash set back end
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define HSC_ASSERT(name, clk, rst, prop) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error("assertion failed");
`define HSC_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define HSC_ASSERT(name, clk, rst, prop)
`define HSC_ASSERT_ALWAYS(name, clk, prop)
`endif
`endif

>>> sv/hsc_pkg.sv
// constants and types of the chained hash set
// no dependencies
`default_nettype none
package hsc_pkg;
  localparam int NUM_BUCKETS  = 128;
  localparam int POOL_ENTRIES = 1024;
  localparam int BUCKET_W     = $clog2(NUM_BUCKETS);
  localparam int NODE_W       = $clog2(POOL_ENTRIES);
  localparam int LINK_W       = NODE_W + 1;
  localparam logic [LINK_W-1:0] NIL_LINK = LINK_W'(POOL_ENTRIES);
  localparam int MAX_KEY_BYTES = 11;
  localparam int TAG_W        = 28;
  localparam int Q_DEPTH      = 2;

  localparam logic [1:0] CMD_INS  = 2'd0;
  localparam logic [1:0] CMD_DEL  = 2'd1;
  localparam logic [1:0] CMD_FIND = 2'd2;
  localparam logic [1:0] CMD_NOP  = 2'd3;

  localparam logic [2:0] ST_DONE    = 3'd0;
  localparam logic [2:0] ST_PRESENT = 3'd1;
  localparam logic [2:0] ST_ABSENT  = 3'd2;
  localparam logic [2:0] ST_BAD_LEN = 3'd3;
  localparam logic [2:0] ST_FULL    = 3'd4;

  localparam logic [1:0] CLS_RUN = 2'd0;
  localparam logic [1:0] CLS_BAD = 2'd1;
  localparam logic [1:0] CLS_NOP = 2'd2;

  typedef struct packed {
    logic [1:0]          cls;
    logic [1:0]          cmd;
    logic [63:0]         lo;
    logic [TAG_W-1:0]    tag;
    logic [BUCKET_W-1:0] bucket;
  } job_t;
endpackage
`default_nettype wire

>>> sv/hsc_ram.sv
// generic single write, single read ram with registered read
// no dependencies
`default_nettype none
module hsc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

>>> sv/hsc_front.sv
// front end: masks the key, builds the tag and the bucket, classifies the command
// depends on hsc_pkg
`default_nettype none
module hsc_front import hsc_pkg::*; (
  input  wire logic [1:0]  cmd,
  input  wire logic [63:0] key_low,
  input  wire logic [23:0] key_high,
  input  wire logic [3:0]  key_len,
  output job_t             job
);
  logic [7:0]  bytes [MAX_KEY_BYTES];
  logic [11:0] sum;
  logic [63:0] lo;
  logic [23:0] hi;

  always_comb begin
    for (int i = 0; i < MAX_KEY_BYTES; i++) begin
      if (i < 8) begin
        bytes[i] = (4'(i) < key_len) ? key_low[8*i +: 8] : 8'd0;
      end else begin
        bytes[i] = (4'(i) < key_len) ? key_high[8*(i-8) +: 8] : 8'd0;
      end
    end
    for (int i = 0; i < 8; i++) begin
      lo[8*i +: 8] = bytes[i];
    end
    for (int i = 0; i < 3; i++) begin
      hi[8*i +: 8] = bytes[i+8];
    end
    sum = ((12'(bytes[0]) + 12'(bytes[1])) + (12'(bytes[2]) + 12'(bytes[3])))
        + ((12'(bytes[4]) + 12'(bytes[5])) + (12'(bytes[6]) + 12'(bytes[7])))
        + ((12'(bytes[8]) + 12'(bytes[9])) + 12'(bytes[10]));
    job.cmd    = cmd;
    job.lo     = lo;
    job.tag    = {key_len, hi};
    job.bucket = sum[BUCKET_W-1:0];
    if (cmd != CMD_INS && cmd != CMD_DEL && cmd != CMD_FIND) begin
      job.cls = CLS_NOP;
    end else if (key_len == 4'd0 || key_len > 4'(MAX_KEY_BYTES)) begin
      job.cls = CLS_BAD;
    end else begin
      job.cls = CLS_RUN;
    end
  end
endmodule
`default_nettype wire

>>> sv/hsc_queue.sv
// short queue of classified commands between front and back
// depends on hsc_pkg
`default_nettype none
module hsc_queue import hsc_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire job_t push_job,
  output logic      full,
  input  wire logic pop,
  output logic      valid,
  output job_t      head
);
  localparam int PW = $clog2(Q_DEPTH);
  job_t          slots [Q_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [PW:0]   count;

  assign full  = count == (PW+1)'(Q_DEPTH);
  assign valid = count != '0;
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      slots[wr_ptr] <= push_job;
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop && valid) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + (PW+1)'(push && !full) - (PW+1)'(pop && valid);
    end
  end
endmodule
`default_nettype wire

>>> sv/hsc_back.sv
// back end: walks one bucket chain, updates the pool and the free list
// depends on hsc_pkg, hsc_ram and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"
module hsc_back import hsc_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       job_valid,
  input  wire job_t       job,
  output logic            job_pop,
  output logic            res_valid,
  input  wire logic       res_ready,
  output logic            res_found,
  output logic [2:0]      res_status
);
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_RDH   = 3'd1;
  localparam logic [2:0] S_CHK   = 3'd2;
  localparam logic [2:0] S_CMP   = 3'd3;
  localparam logic [2:0] S_ACT   = 3'd4;
  localparam logic [2:0] S_ALLOC = 3'd5;
  localparam logic [2:0] S_DEL2  = 3'd6;
  localparam logic [2:0] S_OUT   = 3'd7;

  logic [2:0]             state;
  job_t                   cur;
  logic [LINK_W-1:0]      p;
  logic [LINK_W-1:0]      q;
  logic [LINK_W-1:0]      head_link;
  logic [LINK_W-1:0]      nnext;
  logic                   hit;
  logic [LINK_W-1:0]      free_head;
  logic [LINK_W-1:0]      fresh;
  logic [NUM_BUCKETS-1:0] bvalid;
  logic                   found;
  logic [2:0]             status;

  logic [LINK_W-1:0] bh_rdata;
  logic [63:0]       kl_rdata;
  logic [TAG_W-1:0]  kh_rdata;
  logic [LINK_W-1:0] nx_rdata;
  logic              bh_we;
  logic [LINK_W-1:0] bh_wdata;
  logic              nx_we;
  logic [NODE_W-1:0] nx_waddr;
  logic [LINK_W-1:0] nx_wdata;
  logic              ins_we;
  logic [NODE_W-1:0] node_raddr;
  logic              from_fresh;
  logic              key_match;
  logic [LINK_W-1:0] first_link;

  assign from_fresh = free_head >= fresh;
  assign key_match  = kl_rdata == cur.lo && kh_rdata == cur.tag;
  assign first_link = bvalid[cur.bucket] ? bh_rdata : NIL_LINK;
  assign node_raddr = (state == S_ACT) ? free_head[NODE_W-1:0] :
                      (state == S_CHK) ? first_link[NODE_W-1:0] : p[NODE_W-1:0];
  assign job_pop    = state == S_IDLE && job_valid;

  // insert at chain head, either straight from the fresh region or after a free list read
  assign ins_we = (state == S_ALLOC) || (state == S_ACT && cur.cmd == CMD_INS && !hit
                  && free_head != NIL_LINK && from_fresh);

  always_comb begin
    bh_we    = 1'b0;
    bh_wdata = free_head;
    nx_we    = 1'b0;
    nx_waddr = free_head[NODE_W-1:0];
    nx_wdata = head_link;
    if (ins_we) begin
      bh_we = 1'b1;
      nx_we = 1'b1;
    end else if (state == S_ACT && cur.cmd == CMD_DEL && hit) begin
      if (q != NIL_LINK) begin
        nx_we    = 1'b1;
        nx_waddr = q[NODE_W-1:0];
        nx_wdata = nnext;
      end else begin
        bh_we    = 1'b1;
        bh_wdata = nnext;
      end
    end else if (state == S_DEL2) begin
      nx_we    = 1'b1;
      nx_waddr = p[NODE_W-1:0];
      nx_wdata = free_head;
    end
  end

  hsc_ram #(.WIDTH(LINK_W), .DEPTH(NUM_BUCKETS)) u_bucket_head (
    .clk(clk), .we(bh_we), .waddr(cur.bucket), .wdata(bh_wdata),
    .raddr(cur.bucket), .rdata(bh_rdata)
  );
  hsc_ram #(.WIDTH(64), .DEPTH(POOL_ENTRIES)) u_key_low (
    .clk(clk), .we(ins_we), .waddr(free_head[NODE_W-1:0]), .wdata(cur.lo),
    .raddr(node_raddr), .rdata(kl_rdata)
  );
  hsc_ram #(.WIDTH(TAG_W), .DEPTH(POOL_ENTRIES)) u_key_high (
    .clk(clk), .we(ins_we), .waddr(free_head[NODE_W-1:0]), .wdata(cur.tag),
    .raddr(node_raddr), .rdata(kh_rdata)
  );
  hsc_ram #(.WIDTH(LINK_W), .DEPTH(POOL_ENTRIES)) u_node_next (
    .clk(clk), .we(nx_we), .waddr(nx_waddr), .wdata(nx_wdata),
    .raddr(node_raddr), .rdata(nx_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      free_head <= '0;
      fresh     <= '0;
      bvalid    <= '0;
      res_valid <= 1'b0;
    end else begin
      if (res_valid && res_ready && state != S_OUT) begin
        res_valid <= 1'b0;
      end
      if (bh_we) begin
        bvalid[cur.bucket] <= 1'b1;
      end
      unique case (state)
        S_IDLE: begin
          if (job_valid) begin
            cur <= job;
            hit <= 1'b0;
            q   <= NIL_LINK;
            if (job.cls == CLS_RUN) begin
              state <= S_RDH;
            end else begin
              found  <= 1'b0;
              status <= (job.cls == CLS_BAD) ? ST_BAD_LEN : ST_DONE;
              state  <= S_OUT;
            end
          end
        end
        S_RDH: begin
          // first pass waits for the bucket head, later passes for the next node
          state <= (q == NIL_LINK) ? S_CHK : S_CMP;
        end
        S_CHK: begin
          head_link <= first_link;
          p         <= first_link;
          state     <= S_CMP;
        end
        S_CMP: begin
          if (p == NIL_LINK) begin
            state <= S_ACT;
          end else if (key_match) begin
            hit   <= 1'b1;
            nnext <= nx_rdata;
            state <= S_ACT;
          end else begin
            q     <= p;
            p     <= nx_rdata;
            state <= S_RDH;
          end
        end
        S_ACT: begin
          found  <= hit;
          status <= ST_DONE;
          state  <= S_OUT;
          if (cur.cmd == CMD_INS) begin
            if (hit) begin
              status <= ST_PRESENT;
            end else if (free_head == NIL_LINK) begin
              status <= ST_FULL;
            end else if (from_fresh) begin
              free_head <= free_head + 1'b1;
              fresh     <= fresh + 1'b1;
            end else begin
              state <= S_ALLOC;
            end
          end else if (cur.cmd == CMD_DEL) begin
            if (hit) begin
              state <= S_DEL2;
            end else begin
              status <= ST_ABSENT;
            end
          end else if (!hit) begin
            status <= ST_ABSENT;
          end
        end
        S_ALLOC: begin
          free_head <= nx_rdata;
          state     <= S_OUT;
        end
        S_DEL2: begin
          free_head <= p;
          state     <= S_OUT;
        end
        S_OUT: begin
          if (!res_valid || res_ready) begin
            res_valid  <= 1'b1;
            res_found  <= found;
            res_status <= status;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `HSC_ASSERT(a_fresh_bound, clk, rst, fresh <= LINK_W'(POOL_ENTRIES))
  `HSC_ASSERT(a_free_head_order, clk, rst, free_head <= fresh)
  `HSC_ASSERT(a_single_job, clk, rst, job_pop |=> state != S_IDLE)
  `HSC_ASSERT(a_del_hit, clk, rst, state == S_DEL2 |-> hit && p != NIL_LINK)
endmodule
`default_nettype wire

>>> sv/hash_set_chained_top.sv
// hash set of short keys with separate chaining in a fixed node pool
// slave channel carries commands, master channel carries one result per command
// a command enters a two deep queue and is then carried out by the chain walker
// depends on hsc_pkg, hsc_front, hsc_queue and hsc_back
//
// s_tdata holds cmd, key_low, key_high and key_len; m_tdata holds found and status
// every command gives exactly one result, in command order
// a chain walk reads and compares each node of the bucket chain in turn; after the
// bucket head read and the walk, an insert that reuses a freed node goes through an
// allocation step and a delete that hits goes through a free list step before the result
// the queue lets up to two commands be taken while the walker is busy
// bad length and unused commands skip the walk and go straight to the result
// reset empties every bucket and returns the whole pool to the free list at once
// no clearing pass is needed, the block is ready the cycle after reset
// a stalled receiver holds the result; the walker then waits and the queue fills
// before s_tready drops
`default_nettype none
module hash_set_chained_top import hsc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [95:0] s_tdata,  // cmd[1:0], key_low[65:2], key_high[89:66], key_len[93:90]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [7:0]       m_tdata   // found[0], status[3:1]
);
  job_t       fjob;
  job_t       qjob;
  logic       qfull;
  logic       qvalid;
  logic       qpop;
  logic       found;
  logic [2:0] status;

  hsc_front u_front (
    .cmd(s_tdata[1:0]), .key_low(s_tdata[65:2]), .key_high(s_tdata[89:66]),
    .key_len(s_tdata[93:90]), .job(fjob)
  );

  hsc_queue u_queue (
    .clk(clk), .rst(rst), .push(s_tvalid), .push_job(fjob), .full(qfull),
    .pop(qpop), .valid(qvalid), .head(qjob)
  );

  hsc_back u_back (
    .clk(clk), .rst(rst), .job_valid(qvalid), .job(qjob), .job_pop(qpop),
    .res_valid(m_tvalid), .res_ready(m_tready), .res_found(found), .res_status(status)
  );

  assign s_tready = !qfull;
  assign m_tdata  = {4'd0, status, found};
endmodule
`default_nettype wire
